// ===== hw/rtl/isl_pkg.sv =====
// isl_pkg: shared types and constants for the indexed shift list.
// Used by the channel interfaces, the list cell and the top level.
package isl_pkg;

    localparam int CMD_BITS   = 3;
    localparam int INDEX_BITS = 5;
    localparam int VALUE_BITS = 32;
    localparam int COUNT_BITS = 5;
    // wide enough for any position or fill at the largest supported capacity
    localparam int POS_BITS   = 11;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_GET      = 3'd0,
        CMD_SET      = 3'd1,
        CMD_INSERT   = 3'd2,
        CMD_REMOVE   = 3'd3,
        CMD_CONTAINS = 3'd4,
        CMD_APPEND   = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_READ,
        OP_WRITE,
        OP_INSERT,
        OP_REMOVE,
        OP_FIND
    } cell_op_t;

    // broadcast to every cell on an accepted request
    typedef struct packed {
        cell_op_t                op;
        logic [POS_BITS-1:0]     pos;
        logic [POS_BITS-1:0]     fill;
        logic [VALUE_BITS-1:0]   word;
    } isl_cmd_t;

    // per-cell query result, registered inside the cell
    typedef struct packed {
        logic                    hit;
        logic [VALUE_BITS-1:0]   rd;
    } isl_cell_rsp_t;

endpackage

// ===== hw/rtl/isl_req_if.sv =====
// isl_req_if: request channel of the indexed shift list.
// Depends on isl_pkg for field widths.
interface isl_req_if
    import isl_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [CMD_BITS-1:0]     command;
    logic [INDEX_BITS-1:0]   index;
    logic [VALUE_BITS-1:0]   value;

    modport source (output valid, output command, output index, output value, input ready);
    modport sink   (input valid, input command, input index, input value, output ready);
endinterface

// ===== hw/rtl/isl_rsp_if.sv =====
// isl_rsp_if: response channel of the indexed shift list.
// Depends on isl_pkg for field widths.
interface isl_rsp_if
    import isl_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic                    ok;
    logic [VALUE_BITS-1:0]   read_value;
    logic                    found;
    logic [COUNT_BITS-1:0]   count;
    logic                    empty_res;

    modport source (
        output valid, output ok, output read_value, output found,
        output count, output empty_res, input ready
    );
    modport sink (
        input valid, input ok, input read_value, input found,
        input count, input empty_res, output ready
    );
endinterface

// ===== hw/rtl/isl_cell.sv =====
// isl_cell: one list position; holds an entry, shifts with its neighbors,
// and answers read and membership queries. Depends on isl_pkg.
module isl_cell
    import isl_pkg::*;
#(
    parameter int WORD_BITS = 32,
    parameter int POS       = 0
) (
    input  logic                   clk,
    input  logic                   en,
    input  isl_cmd_t               cmd,
    input  logic [WORD_BITS-1:0]   lower_data,
    input  logic [WORD_BITS-1:0]   upper_data,
    output logic [WORD_BITS-1:0]   data,
    output isl_cell_rsp_t          rsp
);

    localparam logic [POS_BITS-1:0] MY_POS = POS_BITS'(POS);

    logic [WORD_BITS-1:0] data_reg, data_next;
    logic [WORD_BITS-1:0] word_w;
    isl_cell_rsp_t        rsp_reg, rsp_next;

    assign word_w = WORD_BITS'(cmd.word);

    always_comb
    begin
        data_next = data_reg;
        rsp_next  = '0;
        unique case (cmd.op)
            OP_HOLD:
            begin
            end
            OP_READ:
            begin
                if (MY_POS == cmd.pos)
                    rsp_next.rd = VALUE_BITS'(data_reg);
            end
            OP_WRITE:
            begin
                if (MY_POS == cmd.pos)
                    data_next = word_w;
            end
            OP_INSERT:
            begin
                if (MY_POS == cmd.pos)
                    data_next = word_w;
                else if (MY_POS > cmd.pos)
                    data_next = lower_data;
            end
            OP_REMOVE:
            begin
                if (MY_POS >= cmd.pos)
                    data_next = upper_data;
            end
            OP_FIND:
            begin
                if (MY_POS < cmd.fill && data_reg == word_w)
                    rsp_next.hit = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
            rsp_reg  <= rsp_next;
        end
    end

    assign data = data_reg;
    assign rsp  = rsp_reg;

endmodule

// ===== hw/rtl/indexed_shift_list.sv =====
// indexed_shift_list: fixed-capacity ordered word list built as a row of cells.
// Depends on isl_pkg, isl_req_if, isl_rsp_if and isl_cell.
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   command, index, value
//   rsp      out  valid/ready   ok, read_value, found, count, empty_res
//   cfg      in   cfg_we        cfg_wdata (compare_enable)
//
// One request per cycle while req.ready is high. The cells all read, shift,
// write or compare in the cycle the request is accepted and register their
// query results; the output stage merges these into the output register.
// req.ready drops only while both stages hold responses and rsp is stalled.
// Reset clears the fill count and sets compare_enable; entries need no clearing.
module indexed_shift_list
    import isl_pkg::*;
#(
    parameter int CAPACITY  = 16,
    parameter int WORD_BITS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    isl_req_if.sink    req,
    isl_rsp_if.source  rsp,
    input  logic       cfg_we,
    input  logic       cfg_wdata
);

    localparam int FW = $clog2(CAPACITY + 1);

    logic                    cmp_en_reg;
    logic [FW-1:0]           fill_reg, fill_next;
    logic                    s1_vld_reg, s1_vld_next;
    logic                    s1_ok_reg;
    logic [FW-1:0]           s1_fill_reg;
    logic                    out_vld_reg, out_vld_next;
    logic                    out_ok_reg;
    logic [VALUE_BITS-1:0]   out_rd_reg, out_rd_next;
    logic                    out_found_reg, out_found_next;
    logic [COUNT_BITS-1:0]   out_count_reg;
    logic                    out_empty_reg;

    logic                    accept, s1_adv, ok_c, full;
    logic [POS_BITS-1:0]     idx_x, fill_x;
    isl_cmd_t                cmd;
    logic [WORD_BITS-1:0]    cell_data [CAPACITY];
    isl_cell_rsp_t           cell_rsp  [CAPACITY];

    assign s1_adv    = s1_vld_reg && (!out_vld_reg || rsp.ready);
    assign req.ready = !s1_vld_reg || s1_adv;
    assign accept    = req.valid && req.ready;

    assign idx_x  = POS_BITS'(req.index);
    assign fill_x = POS_BITS'(fill_reg);
    assign full   = (fill_x == POS_BITS'(CAPACITY));

    // command decode
    always_comb
    begin
        cmd.op    = OP_HOLD;
        cmd.pos   = idx_x;
        cmd.fill  = fill_x;
        cmd.word  = req.value;
        ok_c      = 1'b0;
        fill_next = fill_reg;
        unique case (req.command)
            CMD_GET:
            begin
                if (idx_x < fill_x)
                begin
                    ok_c   = 1'b1;
                    cmd.op = OP_READ;
                end
            end
            CMD_SET:
            begin
                if (idx_x < fill_x)
                begin
                    ok_c   = 1'b1;
                    cmd.op = OP_WRITE;
                end
            end
            CMD_INSERT:
            begin
                if (idx_x <= fill_x && !full)
                begin
                    ok_c      = 1'b1;
                    cmd.op    = OP_INSERT;
                    fill_next = fill_reg + 1'b1;
                end
            end
            CMD_REMOVE:
            begin
                if (idx_x < fill_x)
                begin
                    ok_c      = 1'b1;
                    cmd.op    = OP_REMOVE;
                    fill_next = fill_reg - 1'b1;
                end
            end
            CMD_CONTAINS:
            begin
                ok_c = 1'b1;
                if (cmp_en_reg)
                    cmd.op = OP_FIND;
            end
            CMD_APPEND:
            begin
                if (!full)
                begin
                    ok_c      = 1'b1;
                    cmd.op    = OP_WRITE;
                    cmd.pos   = fill_x;
                    fill_next = fill_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [WORD_BITS-1:0] lower_w, upper_w;
        if (i == 0)
        begin : g_first
            assign lower_w = cell_data[i];
        end
        else
        begin : g_lower
            assign lower_w = cell_data[i-1];
        end
        if (i == CAPACITY - 1)
        begin : g_last
            assign upper_w = cell_data[i];
        end
        else
        begin : g_upper
            assign upper_w = cell_data[i+1];
        end

        isl_cell #(
            .WORD_BITS (WORD_BITS),
            .POS       (i)
        ) u_cell (
            .clk        (clk),
            .en         (accept),
            .cmd        (cmd),
            .lower_data (lower_w),
            .upper_data (upper_w),
            .data       (cell_data[i]),
            .rsp        (cell_rsp[i])
        );
    end

    // merge per-cell query results
    always_comb
    begin
        out_rd_next    = '0;
        out_found_next = 1'b0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            out_rd_next    = out_rd_next | cell_rsp[k].rd;
            out_found_next = out_found_next | cell_rsp[k].hit;
        end
    end

    always_comb
    begin
        s1_vld_next = s1_vld_reg;
        if (accept)
            s1_vld_next = 1'b1;
        else if (s1_adv)
            s1_vld_next = 1'b0;
        out_vld_next = out_vld_reg;
        if (s1_adv)
            out_vld_next = 1'b1;
        else if (rsp.ready)
            out_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_en_reg  <= 1'b1;
            fill_reg    <= '0;
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                cmp_en_reg <= cfg_wdata;
            if (accept)
                fill_reg <= fill_next;
            s1_vld_reg  <= s1_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ok_reg   <= ok_c;
            s1_fill_reg <= fill_next;
        end
        if (s1_adv)
        begin
            out_ok_reg    <= s1_ok_reg;
            out_rd_reg    <= out_rd_next;
            out_found_reg <= out_found_next;
            out_count_reg <= COUNT_BITS'(s1_fill_reg);
            out_empty_reg <= (s1_fill_reg == '0);
        end
    end

    assign rsp.valid      = out_vld_reg;
    assign rsp.ok         = out_ok_reg;
    assign rsp.read_value = out_rd_reg;
    assign rsp.found      = out_found_reg;
    assign rsp.count      = out_count_reg;
    assign rsp.empty_res  = out_empty_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        POS_BITS'(fill_reg) <= POS_BITS'(CAPACITY))
        else $error("fill exceeds capacity");

    a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && ok_c && req.command == CMD_REMOVE)
        |=> fill_reg == FW'($past(fill_reg) - 1'b1))
        else $error("remove did not shrink fill");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> (s1_vld_reg && out_vld_reg && !rsp.ready))
        else $error("request stalled without a full pipeline");

    a_failed_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !ok_c) |=> $stable(fill_reg))
        else $error("failed request changed fill");
`endif

endmodule

// ===== tb/isl_list_checker.sv =====
// isl_list_checker: watches the request, response and config ports of the indexed shift list,
// predicts each response and compares it field by field.
// Depends on isl_pkg, isl_req_if and isl_rsp_if.
`timescale 1ns / 100ps

module isl_list_checker
    import isl_pkg::*;
#(
    parameter int CAPACITY  = 16,
    parameter int WORD_BITS = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    isl_req_if        req,
    isl_rsp_if        rsp,
    input  logic      cfg_we,
    input  logic      cfg_wdata,
    output int        fail_count,
    output int        pending_count
);

    localparam int EW = $clog2(CAPACITY);

    typedef struct {
        logic                    ok;
        logic [VALUE_BITS-1:0]   read_value;
        logic                    found;
        logic [COUNT_BITS-1:0]   count;
        logic                    empty_res;
    } list_result_t;

    logic [WORD_BITS-1:0] entries [CAPACITY];
    int                   fill;
    logic                 compare_en;
    list_result_t         expected_rsp_q [$];

    function automatic list_result_t list_apply(logic [CMD_BITS-1:0] cmd,
                                                logic [INDEX_BITS-1:0] idx,
                                                logic [VALUE_BITS-1:0] value);
        list_result_t         res;
        logic [WORD_BITS-1:0] word;
        int                   pos;
        word = WORD_BITS'(value);
        res.ok         = 1'b0;
        res.read_value = '0;
        res.found      = 1'b0;
        case (cmd) inside
            CMD_GET:
                if (idx < fill)
                begin
                    res.read_value = VALUE_BITS'(entries[EW'(idx)]);
                    res.ok = 1'b1;
                end
            CMD_SET:
                if (idx < fill)
                begin
                    entries[EW'(idx)] = word;
                    res.ok = 1'b1;
                end
            CMD_INSERT, CMD_APPEND:
            begin
                pos = (cmd == CMD_APPEND) ? fill : int'(idx);
                if (pos <= fill && fill < CAPACITY)
                begin
                    for (int k = fill; k > pos; k--)
                        entries[EW'(k)] = entries[EW'(k-1)];
                    entries[EW'(pos)] = word;
                    fill++;
                    res.ok = 1'b1;
                end
            end
            CMD_REMOVE:
                if (idx < fill)
                begin
                    for (int k = idx; k + 1 < fill; k++)
                        entries[EW'(k)] = entries[EW'(k+1)];
                    fill--;
                    res.ok = 1'b1;
                end
            CMD_CONTAINS:
            begin
                res.ok = 1'b1;
                if (compare_en)
                    for (int k = 0; k < fill; k++)
                        if (entries[EW'(k)] == word)
                            res.found = 1'b1;
            end
            default: ;
        endcase
        res.count     = COUNT_BITS'(fill);
        res.empty_res = (fill == 0);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        list_result_t exp_rsp;
        if (!rst_n)
        begin
            expected_rsp_q.delete();
            fill          = 0;
            compare_en    = 1'b1;
            fail_count    = 0;
            pending_count = 0;
        end
        else
        begin
            if (cfg_we)
                compare_en = cfg_wdata;
            if (rsp.valid && rsp.ready)
            begin
                if (expected_rsp_q.size() == 0)
                begin
                    $error("response with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    exp_rsp = expected_rsp_q.pop_front();
                    if (rsp.ok !== exp_rsp.ok)
                    begin
                        $error("ok mismatch: expected %0d, actual %0d", exp_rsp.ok, rsp.ok);
                        fail_count++;
                    end
                    if (rsp.read_value !== exp_rsp.read_value)
                    begin
                        $error("read_value mismatch: expected %h, actual %h",
                               exp_rsp.read_value, rsp.read_value);
                        fail_count++;
                    end
                    if (rsp.found !== exp_rsp.found)
                    begin
                        $error("found mismatch: expected %0d, actual %0d",
                               exp_rsp.found, rsp.found);
                        fail_count++;
                    end
                    if (rsp.count !== exp_rsp.count)
                    begin
                        $error("count mismatch: expected %0d, actual %0d",
                               exp_rsp.count, rsp.count);
                        fail_count++;
                    end
                    if (rsp.empty_res !== exp_rsp.empty_res)
                    begin
                        $error("empty_res mismatch: expected %0d, actual %0d",
                               exp_rsp.empty_res, rsp.empty_res);
                        fail_count++;
                    end
                end
            end
            if (req.valid && req.ready)
                expected_rsp_q.push_back(list_apply(req.command, req.index, req.value));
            pending_count = expected_rsp_q.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
// tb: stimulus and verdict for the indexed shift list; directed requests, then
// random grow/shrink episodes with compare_enable off, on, then off. Depends on
// isl_pkg, isl_req_if, isl_rsp_if, indexed_shift_list and isl_list_checker.
`timescale 1ns / 100ps

module tb;
    import isl_pkg::*;

    localparam logic [CMD_BITS-1:0] CMD_UNUSED_LO = 3'd6;
    localparam logic [CMD_BITS-1:0] CMD_UNUSED_HI = 3'd7;
    localparam int PHASE_ITEMS  = 430;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT  = 200000;

    typedef enum logic { GROW, SHRINK } trend_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;
    int   fail_count;
    int   pending_count;
    int   cycle_count = 0;
    int   burst_left = 0;
    logic [VALUE_BITS-1:0] word_pool [8];

    isl_req_if req_ch ();
    isl_rsp_if rsp_ch ();

    indexed_shift_list u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    isl_list_checker u_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req_ch),
        .rsp           (rsp_ch),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // response stall pattern: free-running, random, or long stalls; the pattern is re-picked at random
    initial
    begin
        int stall_mode;
        int stall_left;
        int mode_left;
        rsp_ch.ready = 1'b0;
        stall_mode   = 0;
        stall_left   = 0;
        mode_left    = 0;
        forever
        begin
            @(negedge clk);
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                mode_left  = 64;
            end
            mode_left--;
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready = 1'b0;
            end
            else if (stall_mode == 1)
                rsp_ch.ready = ($urandom_range(0, 3) != 0);
            else if (stall_mode == 2 && $urandom_range(0, 5) == 0)
            begin
                stall_left   = $urandom_range(0, 5);
                rsp_ch.ready = 1'b0;
            end
            else
                rsp_ch.ready = 1'b1;
        end
    end

    task automatic send_request(logic [CMD_BITS-1:0] cmd, logic [INDEX_BITS-1:0] idx,
                                logic [VALUE_BITS-1:0] value);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                req_ch.valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        req_ch.valid   = 1'b1;
        req_ch.command = cmd;
        req_ch.index   = idx;
        req_ch.value   = value;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
        burst_left--;
    endtask

    task automatic write_compare_enable(logic enable);
        req_ch.valid = 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = enable;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    function automatic logic [CMD_BITS-1:0] pick_command(trend_t trend);
        int r;
        r = $urandom_range(0, 99);
        if (r >= 97)
            return (r == 99) ? CMD_UNUSED_HI : CMD_UNUSED_LO;
        if (trend == GROW)
        begin
            if (r < 35) return CMD_APPEND;
            if (r < 55) return CMD_INSERT;
            if (r < 65) return CMD_GET;
            if (r < 75) return CMD_SET;
            if (r < 88) return CMD_CONTAINS;
            return CMD_REMOVE;
        end
        if (r < 45) return CMD_REMOVE;
        if (r < 57) return CMD_GET;
        if (r < 67) return CMD_SET;
        if (r < 80) return CMD_CONTAINS;
        if (r < 89) return CMD_INSERT;
        return CMD_APPEND;
    endfunction

    function automatic logic [INDEX_BITS-1:0] pick_index(trend_t trend);
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return INDEX_BITS'($urandom_range(17, 31));
        if (trend == SHRINK && r < 50)
            return INDEX_BITS'($urandom_range(0, 3));
        return INDEX_BITS'($urandom_range(0, 16));
    endfunction

    function automatic logic [VALUE_BITS-1:0] pick_value();
        if ($urandom_range(0, 1) == 0)
            return word_pool[3'($urandom_range(0, 7))];
        return VALUE_BITS'($urandom());
    endfunction

    task automatic random_phase(int items);
        trend_t trend;
        int     episode_left;
        trend        = GROW;
        episode_left = 0;
        for (int n = 0; n < items; n++)
        begin
            if (episode_left == 0)
            begin
                trend        = (trend == GROW) ? SHRINK : GROW;
                episode_left = $urandom_range(20, 60);
            end
            episode_left--;
            send_request(pick_command(trend), pick_index(trend), pick_value());
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.command = CMD_GET;
        req_ch.index   = '0;
        req_ch.value   = '0;
        word_pool[0] = '0;
        word_pool[1] = '1;
        for (int k = 2; k < 8; k++)
            word_pool[3'(k)] = VALUE_BITS'($urandom());
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty list: out-of-range requests and a membership query
        send_request(CMD_GET,      5'd0,  32'h0000_0001);
        send_request(CMD_REMOVE,   5'd0,  32'h0);
        send_request(CMD_SET,      5'd0,  32'h1234_5678);
        send_request(CMD_INSERT,   5'd1,  32'hDEAD_BEEF);
        send_request(CMD_CONTAINS, 5'd0,  32'h0);
        // build, shift, read back, overwrite, search, out-of-range and unused commands, remove
        send_request(CMD_INSERT,   5'd0,  32'hFFFF_FFFF);
        send_request(CMD_APPEND,   5'd31, 32'h0);
        send_request(CMD_INSERT,   5'd1,  32'h8000_0001);
        send_request(CMD_INSERT,   5'd4,  32'h1);
        send_request(CMD_INSERT,   5'd3,  32'h7FFF_FFFE);
        send_request(CMD_GET,      5'd0,  32'h0);
        send_request(CMD_GET,      5'd3,  32'h0);
        send_request(CMD_GET,      5'd4,  32'h0);
        send_request(CMD_SET,      5'd1,  32'hA5A5_5A5A);
        send_request(CMD_GET,      5'd1,  32'h0);
        send_request(CMD_CONTAINS, 5'd0,  32'hA5A5_5A5A);
        send_request(CMD_CONTAINS, 5'd0,  32'h8000_0001);
        send_request(CMD_GET,      5'd16, 32'h0);
        send_request(CMD_SET,      5'd31, 32'hFFFF_FFFF);
        send_request(CMD_UNUSED_LO, 5'd0, 32'hFFFF_FFFF);
        send_request(CMD_UNUSED_HI, 5'd1, 32'h0);
        send_request(CMD_REMOVE,   5'd0,  32'h0);
        send_request(CMD_REMOVE,   5'd3,  32'h0);
        send_request(CMD_GET,      5'd0,  32'h0);

        write_compare_enable(1'b0);
        random_phase(PHASE_ITEMS);
        write_compare_enable(1'b1);
        random_phase(PHASE_ITEMS);
        write_compare_enable(1'b0);
        random_phase(PHASE_ITEMS);

        req_ch.valid = 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
